### design/dltq_pkg.sv
// dltq_pkg: shared types and codes for the delta list timer queue
// no dependencies

package dltq_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_CANCEL = 2'd2,
        OP_DONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_STARTED   = 3'd0,
        ST_ARMED_ERR = 3'd1,
        ST_CANCELLED = 3'd2,
        ST_WAS_IDLE  = 3'd3,
        ST_BUSY      = 3'd4,
        ST_DONE_ACK  = 3'd5,
        ST_FIRED     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        SLOT_IDLE  = 2'd0,
        SLOT_ARMED = 2'd1,
        SLOT_FIRED = 2'd2
    } t_slot;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_TICK,
        BK_TICK_END,
        BK_START,
        BK_REPLY
    } t_bk_state;

    localparam int MAX_FIRE = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  timer_id;
        logic [31:0] ticks;
    } t_cmd;

endpackage

### design/dltq_front.sv
// dltq_front: two-entry command queue in front of the list engine
// depends on dltq_pkg

module dltq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dltq_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output dltq_pkg::t_cmd o_cmd
);

    dltq_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### design/dltq_back.sv
// dltq_back: list engine, walks the delta list and emits results
// depends on dltq_pkg

module dltq_back #(
    parameter int NUM_TIMERS  = 16,
    parameter int DELAY_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dltq_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_status,
    output logic [3:0]     o_slot_out,
    output logic           o_last
);

    localparam int LW = $clog2(NUM_TIMERS + 1);
    localparam int IW = $clog2(NUM_TIMERS);
    localparam int NW = $clog2(((NUM_TIMERS > dltq_pkg::MAX_FIRE) ?
                                NUM_TIMERS : dltq_pkg::MAX_FIRE) + 1);
    localparam logic [LW-1:0] NIL = LW'(NUM_TIMERS);

    logic [LW-1:0]          r_next [NUM_TIMERS];
    logic [LW-1:0]          r_prev [NUM_TIMERS];
    logic [DELAY_WIDTH-1:0] r_dly  [NUM_TIMERS];
    dltq_pkg::t_slot        r_st   [NUM_TIMERS];
    logic [LW-1:0]          r_head;

    dltq_pkg::t_bk_state    r_state, n_state;
    logic [LW-1:0]          r_cur, r_p;
    logic [DELAY_WIDTH-1:0] r_t;
    logic [IW-1:0]          r_id;
    logic [NW-1:0]          r_n;
    logic                   r_ov;
    logic [2:0]             r_ostat;
    logic [3:0]             r_oslot;
    logic                   r_olast;

    logic                   cur_ok;
    logic [IW-1:0]          cur_i;
    logic [DELAY_WIDTH-1:0] cur_d;
    logic                   id_ok;
    logic [IW-1:0]          cmd_i;
    logic [LW-1:0]          cp, cn;
    logic [DELAY_WIDTH:0]   sum;
    logic                   out_free;
    logic                   take;
    logic                   start_go;
    logic                   fire;
    logic [LW-1:0]          nx;
    logic                   nx_fire;
    logic                   ov_set;
    dltq_pkg::t_status      acc_stat;

    assign cur_ok   = (r_cur < NIL);
    assign cur_i    = r_cur[IW-1:0];
    assign cur_d    = r_dly[cur_i];
    assign id_ok    = ({28'd0, i_cmd.timer_id} < 32'(NUM_TIMERS));
    assign cmd_i    = IW'(i_cmd.timer_id);
    assign cp       = r_prev[cmd_i];
    assign cn       = r_next[cmd_i];
    assign sum      = {1'b0, r_dly[cn[IW-1:0]]} + {1'b0, r_dly[cmd_i]};
    assign out_free = !r_ov || i_ready;
    assign o_ready  = (r_state == dltq_pkg::BK_IDLE) && out_free;
    assign o_valid  = r_ov;
    assign o_status = r_ostat;
    assign o_slot_out = r_oslot;
    assign o_last   = r_olast;

    assign take     = i_valid && o_ready;
    assign start_go = take && i_cmd.op == dltq_pkg::OP_START && id_ok &&
                      r_st[cmd_i] == dltq_pkg::SLOT_IDLE;
    // fire one head slot, and look one slot ahead to mark the last one
    assign fire     = out_free && cur_ok && cur_d == '0 &&
                      r_n < NW'(dltq_pkg::MAX_FIRE);
    assign nx       = r_next[cur_i];
    assign nx_fire  = (nx < NIL) && (r_dly[nx[IW-1:0]] == '0) &&
                      (r_n < NW'(dltq_pkg::MAX_FIRE - 1));
    assign ov_set   = (take && i_cmd.op != dltq_pkg::OP_TICK && !start_go) ||
                      (r_state == dltq_pkg::BK_TICK && fire) ||
                      (r_state == dltq_pkg::BK_REPLY && out_free);

    always_comb begin
        acc_stat = dltq_pkg::ST_WAS_IDLE;
        if (id_ok) begin
            case (i_cmd.op)
                dltq_pkg::OP_START: begin
                    if (r_st[cmd_i] == dltq_pkg::SLOT_ARMED)
                        acc_stat = dltq_pkg::ST_ARMED_ERR;
                    else if (r_st[cmd_i] == dltq_pkg::SLOT_FIRED)
                        acc_stat = dltq_pkg::ST_BUSY;
                    else
                        acc_stat = dltq_pkg::ST_STARTED;
                end
                dltq_pkg::OP_CANCEL: begin
                    if (r_st[cmd_i] == dltq_pkg::SLOT_FIRED)
                        acc_stat = dltq_pkg::ST_BUSY;
                    else if (r_st[cmd_i] == dltq_pkg::SLOT_ARMED)
                        acc_stat = dltq_pkg::ST_CANCELLED;
                end
                dltq_pkg::OP_DONE: begin
                    if (r_st[cmd_i] == dltq_pkg::SLOT_FIRED)
                        acc_stat = dltq_pkg::ST_DONE_ACK;
                    else if (r_st[cmd_i] == dltq_pkg::SLOT_ARMED)
                        acc_stat = dltq_pkg::ST_ARMED_ERR;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dltq_pkg::BK_IDLE: begin
                if (take) begin
                    if (i_cmd.op == dltq_pkg::OP_TICK)
                        n_state = dltq_pkg::BK_TICK;
                    else if (start_go)
                        n_state = dltq_pkg::BK_START;
                end
            end
            dltq_pkg::BK_TICK: begin
                if (out_free && !fire)
                    n_state = dltq_pkg::BK_TICK_END;
            end
            dltq_pkg::BK_TICK_END: n_state = dltq_pkg::BK_IDLE;
            dltq_pkg::BK_START: begin
                if (!cur_ok || r_t < cur_d || r_n == NW'(NUM_TIMERS))
                    n_state = dltq_pkg::BK_REPLY;
            end
            dltq_pkg::BK_REPLY: if (out_free) n_state = dltq_pkg::BK_IDLE;
            default: n_state = dltq_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dltq_pkg::BK_IDLE: begin
                if (take) begin
                    r_cur   <= r_head;
                    r_p     <= NIL;
                    r_t     <= i_cmd.ticks[DELAY_WIDTH-1:0];
                    r_id    <= cmd_i;
                    r_n     <= '0;
                    r_ostat <= acc_stat;
                    r_oslot <= i_cmd.timer_id;
                    r_olast <= 1'b1;
                    if (i_cmd.op == dltq_pkg::OP_CANCEL && id_ok &&
                        r_st[cmd_i] == dltq_pkg::SLOT_ARMED) begin
                        if (cp < NIL) r_next[cp[IW-1:0]] <= cn;
                        if (cn < NIL) begin
                            r_prev[cn[IW-1:0]] <= cp;
                            r_dly[cn[IW-1:0]] <= sum[DELAY_WIDTH] ? '1 :
                                                 sum[DELAY_WIDTH-1:0];
                        end
                        r_next[cmd_i] <= NIL;
                        r_prev[cmd_i] <= NIL;
                    end
                end
            end
            dltq_pkg::BK_TICK: begin
                if (fire) begin
                    r_ostat <= dltq_pkg::ST_FIRED;
                    r_oslot <= 4'(r_cur);
                    r_olast <= !nx_fire;
                    r_n     <= r_n + NW'(1);
                    r_cur   <= nx;
                end
            end
            dltq_pkg::BK_TICK_END: begin
                if (cur_ok) begin
                    if (cur_d != '0) r_dly[cur_i] <= cur_d - 1'b1;
                    r_prev[cur_i] <= NIL;
                end
            end
            dltq_pkg::BK_START: begin
                if (cur_ok && r_t < cur_d && r_n != NW'(NUM_TIMERS)) begin
                    // insert before the current slot
                    r_dly[cur_i] <= cur_d - r_t;
                    r_dly[r_id]  <= r_t;
                    r_prev[r_id] <= r_p;
                    r_next[r_id] <= r_cur;
                    if (r_p < NIL) r_next[r_p[IW-1:0]] <= LW'(r_id);
                    r_prev[cur_i] <= LW'(r_id);
                end else if (cur_ok && r_n != NW'(NUM_TIMERS)) begin
                    r_t   <= r_t - cur_d;
                    r_p   <= r_cur;
                    r_cur <= r_next[cur_i];
                    r_n   <= r_n + NW'(1);
                end else begin
                    r_dly[r_id] <= r_t;
                    r_prev[r_id] <= r_p;
                    r_next[r_id] <= cur_ok ? r_cur : NIL;
                    if (r_p < NIL) r_next[r_p[IW-1:0]] <= LW'(r_id);
                    if (cur_ok) r_prev[cur_i] <= LW'(r_id);
                end
            end
            default: ;
        endcase

        if (!i_rst_n) begin
            r_state <= dltq_pkg::BK_IDLE;
            r_head  <= NIL;
            r_ov    <= 1'b0;
            for (int k = 0; k < NUM_TIMERS; k++) r_st[k] <= dltq_pkg::SLOT_IDLE;
        end else begin
            r_state <= n_state;
            r_ov    <= ov_set || (r_ov && !i_ready);
            case (r_state)
                dltq_pkg::BK_IDLE: begin
                    if (take && id_ok) begin
                        if (i_cmd.op == dltq_pkg::OP_CANCEL &&
                            r_st[cmd_i] == dltq_pkg::SLOT_ARMED) begin
                            r_st[cmd_i] <= dltq_pkg::SLOT_IDLE;
                            if (!(cp < NIL)) r_head <= cn;
                        end
                        if (i_cmd.op == dltq_pkg::OP_DONE &&
                            r_st[cmd_i] == dltq_pkg::SLOT_FIRED)
                            r_st[cmd_i] <= dltq_pkg::SLOT_IDLE;
                    end
                end
                dltq_pkg::BK_TICK: begin
                    if (fire) r_st[cur_i] <= dltq_pkg::SLOT_FIRED;
                end
                dltq_pkg::BK_TICK_END: begin
                    r_head <= r_cur;
                end
                dltq_pkg::BK_START: begin
                    if ((cur_ok && r_t < cur_d) || !cur_ok || r_n == NW'(NUM_TIMERS)) begin
                        r_st[r_id] <= dltq_pkg::SLOT_ARMED;
                        if (!(r_p < NIL)) r_head <= LW'(r_id);
                    end
                end
                dltq_pkg::BK_REPLY: begin
                    if (out_free) begin
                        r_ostat <= dltq_pkg::ST_STARTED;
                        r_oslot <= 4'(r_id);
                        r_olast <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### design/delta_list_timer_queue.sv
// delta_list_timer_queue: top level, command queue in front of the list engine
// depends on dltq_pkg, dltq_front, dltq_back

// One-shot timer set kept as a delta list. Each item (tick, start, cancel or
// done) is taken into a two-entry command queue and carried out by the list
// engine one at a time. Cancel and done give one result each. A start on an
// idle slot walks the list one entry a cycle; every start gives one result.
// A tick gives one fired result per cycle, up to 16, then finishes and
// updates the head; the engine holds while the output is not taken. Each
// fired result looks one slot ahead, so the last fired result of a tick
// carries last as soon as it is emitted. A tick on an empty list or with no
// expired head gives no result. The link and delay stores need no clearing
// after reset.
module delta_list_timer_queue #(
    parameter int NUM_TIMERS  = 16,
    parameter int DELAY_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_timer_id,
    input  logic [31:0] i_ticks,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot_out,
    output logic        o_last
);

    dltq_pkg::t_cmd in_cmd, q_cmd;
    logic           q_valid, q_ready;

    // payload bundled for the queue
    assign in_cmd = '{op: i_op, timer_id: i_timer_id, ticks: i_ticks};

    dltq_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    // list engine with a one-entry result register
    dltq_back #(.NUM_TIMERS(NUM_TIMERS), .DELAY_WIDTH(DELAY_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_slot_out(o_slot_out), .o_last(o_last)
    );

endmodule

### design/dltq_checker.sv
// dltq_checker: port-level checks for the timer queue
// depends on dltq_pkg and delta_list_timer_queue ports

module dltq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_status,
    input logic [3:0] o_slot_out,
    input logic       o_last
);

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= dltq_pkg::ST_FIRED)) else $error("status out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_slot_out)
                                   && $stable(o_last)))
        else $error("result changed while stalled");

    a_nonfire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != dltq_pkg::ST_FIRED) |-> o_last)
        else $error("non-tick result not last");

endmodule

bind delta_list_timer_queue dltq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_status(o_status), .o_slot_out(o_slot_out), .o_last(o_last)
);

### dv/delta_list_timer_queue_test.sv
`timescale 1ns / 1ps
// delta_list_timer_queue_test: self-checking bench for the delta list timer queue
// depends on dltq_pkg and delta_list_timer_queue

module delta_list_timer_queue_test;

    localparam int NT = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        dltq_pkg::t_status status;
        logic [3:0]        slot;
        logic              last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic [1:0]  i_op;
    logic [3:0]  i_timer_id;
    logic [31:0] i_ticks;
    logic        i_ready;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [3:0]  o_slot_out;
    logic        o_last;

    delta_list_timer_queue dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_timer_id(i_timer_id), .i_ticks(i_ticks),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_status(o_status), .o_slot_out(o_slot_out), .o_last(o_last)
    );

    // predicted timer list
    int unsigned       head;
    int unsigned       nxt [NT];
    int unsigned       prv [NT];
    logic [31:0]       delta [NT];
    dltq_pkg::t_slot   slot_st [NT];

    t_result pending_results[$];
    int      errors;
    int      results_seen;
    int      items_sent;
    int      fired_seen;
    bit      idle_on;
    int      cycles;
    int      stall_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic void push_result(dltq_pkg::t_status s, int unsigned slot, logic last);
        t_result r;
        r.status = s;
        r.slot = slot[3:0];
        r.last = last;
        pending_results.push_back(r);
    endfunction

    // expiry of head slots, at most MAX_FIRE per tick
    function automatic void predict_tick();
        int unsigned cur;
        int n;
        cur = head;
        n = 0;
        if (cur >= NT) return;
        while (cur < NT && delta[cur] == 0 && n < dltq_pkg::MAX_FIRE) begin
            slot_st[cur] = dltq_pkg::SLOT_FIRED;
            push_result(dltq_pkg::ST_FIRED, cur, 1'b0);
            n++;
            cur = nxt[cur];
        end
        if (cur < NT && delta[cur] != 0) delta[cur] = delta[cur] - 1;
        head = (cur < NT) ? cur : NT;
        if (cur < NT) prv[cur] = NT;
        if (n > 0) pending_results[$].last = 1'b1;
    endfunction

    function automatic dltq_pkg::t_status predict_start(int unsigned id, logic [31:0] t);
        int unsigned p, c;
        int guard;
        p = NT;
        c = head;
        guard = 0;
        if (slot_st[id] == dltq_pkg::SLOT_ARMED) return dltq_pkg::ST_ARMED_ERR;
        if (slot_st[id] == dltq_pkg::SLOT_FIRED) return dltq_pkg::ST_BUSY;
        while (c < NT && guard < NT) begin
            if (t < delta[c]) begin
                delta[c] = delta[c] - t;
                break;
            end
            t = t - delta[c];
            p = c;
            c = nxt[c];
            guard++;
        end
        if (c >= NT) c = NT;
        delta[id] = t;
        prv[id] = p;
        nxt[id] = c;
        if (p < NT) nxt[p] = id;
        else head = id;
        if (c < NT) prv[c] = id;
        slot_st[id] = dltq_pkg::SLOT_ARMED;
        return dltq_pkg::ST_STARTED;
    endfunction

    function automatic dltq_pkg::t_status predict_cancel(int unsigned id);
        int unsigned p, c;
        logic [32:0] sum;
        if (slot_st[id] == dltq_pkg::SLOT_IDLE) return dltq_pkg::ST_WAS_IDLE;
        if (slot_st[id] == dltq_pkg::SLOT_FIRED) return dltq_pkg::ST_BUSY;
        p = prv[id];
        c = nxt[id];
        if (p < NT) nxt[p] = (c < NT) ? c : NT;
        else head = (c < NT) ? c : NT;
        if (c < NT) begin
            prv[c] = (p < NT) ? p : NT;
            sum = {1'b0, delta[c]} + {1'b0, delta[id]};
            delta[c] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        nxt[id] = NT;
        prv[id] = NT;
        slot_st[id] = dltq_pkg::SLOT_IDLE;
        return dltq_pkg::ST_CANCELLED;
    endfunction

    function automatic void predict_item(dltq_pkg::t_op op, logic [3:0] id, logic [31:0] t);
        dltq_pkg::t_status s;
        if (op == dltq_pkg::OP_TICK) begin
            predict_tick();
            return;
        end
        case (op)
            dltq_pkg::OP_START:  s = predict_start(id, t);
            dltq_pkg::OP_CANCEL: s = predict_cancel(id);
            default: begin
                if (slot_st[id] == dltq_pkg::SLOT_FIRED) begin
                    slot_st[id] = dltq_pkg::SLOT_IDLE;
                    s = dltq_pkg::ST_DONE_ACK;
                end else if (slot_st[id] == dltq_pkg::SLOT_ARMED) begin
                    s = dltq_pkg::ST_ARMED_ERR;
                end else begin
                    s = dltq_pkg::ST_WAS_IDLE;
                end
            end
        endcase
        push_result(s, id, 1'b1);
    endfunction

    // sends one item, with an optional idle burst first
    task automatic send_item(dltq_pkg::t_op op, logic [3:0] id, logic [31:0] t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_timer_id <= id;
        i_ticks <= t;
        do @(posedge i_clk); while (!o_ready);
        predict_item(op, id, t);
        items_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // receive side: random stall bursts, compare each taken result
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t unexpected result status=%0d slot=%0d last=%0d",
                             $time, o_status, o_slot_out, o_last);
                    errors <= errors + 1;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (exp_r.status == dltq_pkg::ST_FIRED) fired_seen <= fired_seen + 1;
                    if (o_status !== exp_r.status || o_slot_out !== exp_r.slot
                            || o_last !== exp_r.last) begin
                        $display("%0t mismatch: expected status=%0d slot=%0d last=%0d, got status=%0d slot=%0d last=%0d",
                                 $time, exp_r.status, exp_r.slot, exp_r.last,
                                 o_status, o_slot_out, o_last);
                        errors <= errors + 1;
                    end
                end
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                stall_left <= $urandom_range(0, 4);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        send_item(dltq_pkg::OP_TICK, 4'd0, 32'd0);             // tick on empty list
        send_item(dltq_pkg::OP_CANCEL, 4'd3, 32'd0);           // cancel idle
        send_item(dltq_pkg::OP_DONE, 4'd3, 32'd0);             // done idle
        send_item(dltq_pkg::OP_START, 4'd0, 32'd0);
        send_item(dltq_pkg::OP_START, 4'd15, 32'hFFFF_FFFF);
        send_item(dltq_pkg::OP_START, 4'd5, 32'd3);
        send_item(dltq_pkg::OP_START, 4'd5, 32'd9);            // already armed
        send_item(dltq_pkg::OP_DONE, 4'd5, 32'd0);             // done on armed
        send_item(dltq_pkg::OP_START, 4'd6, 32'hFFFF_FFF0);
        send_item(dltq_pkg::OP_CANCEL, 4'd5, 32'd0);           // successor gets its delta
        send_item(dltq_pkg::OP_TICK, 4'hF, 32'hFFFF_FFFF);     // slot 0 fires
        send_item(dltq_pkg::OP_START, 4'd0, 32'd1);            // busy fired
        send_item(dltq_pkg::OP_CANCEL, 4'd0, 32'd0);           // busy fired
        send_item(dltq_pkg::OP_DONE, 4'd0, 32'd0);
        send_item(dltq_pkg::OP_TICK, 4'd0, 32'd0);             // no expired head
        send_item(dltq_pkg::OP_CANCEL, 4'd6, 32'd0);           // successor slot 15 gets its delta
        send_item(dltq_pkg::OP_CANCEL, 4'd15, 32'd0);
        drain();
    endtask

    // all slots expire together: more than one fired per tick
    task automatic test_mass_fire();
        for (int i = 0; i < NT; i++) send_item(dltq_pkg::OP_START, i[3:0], 32'd0);
        send_item(dltq_pkg::OP_TICK, 4'd0, 32'd0);
        for (int i = 0; i < NT; i++) send_item(dltq_pkg::OP_DONE, i[3:0], 32'd0);
        drain();
    endtask

    task automatic test_random(int count);
        int unsigned r;
        logic [31:0] t;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: t = $urandom_range(0, 3);
                1: t = $urandom_range(0, 20);
                2: t = $urandom;
                default: t = 32'hFFFF_FFFF - $urandom_range(0, 3);
            endcase
            if (r < 40) send_item(dltq_pkg::OP_TICK, 4'($urandom), $urandom);
            else if (r < 65) send_item(dltq_pkg::OP_START, 4'($urandom), t);
            else if (r < 80) send_item(dltq_pkg::OP_CANCEL, 4'($urandom), $urandom);
            else send_item(dltq_pkg::OP_DONE, 4'($urandom), $urandom);
            // occasionally hold the sender until the block is empty
            if (k % 97 == 50) begin
                i_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = dltq_pkg::OP_TICK;
        i_timer_id = '0;
        i_ticks = '0;
        i_ready = 1'b0;
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        fired_seen = 0;
        cycles = 0;
        stall_left = 0;
        idle_on = 1'b1;
        head = NT;
        for (int i = 0; i < NT; i++) begin
            nxt[i] = NT;
            prv[i] = NT;
            delta[i] = '0;
            slot_st[i] = dltq_pkg::SLOT_IDLE;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_mass_fire();
        test_random(230);
        idle_on = 1'b0;
        test_random(60);
        drain();

        $display("covered %0d items and %0d results, %0d of them fired timers",
                 items_sent, results_seen, fired_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d errors, %0d results missing", errors, pending_results.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### delta_list_timer_queue.f
design/dltq_pkg.sv
design/dltq_front.sv
design/dltq_back.sv
design/delta_list_timer_queue.sv
design/dltq_checker.sv
dv/delta_list_timer_queue_test.sv
